// ===== hdl/upload_byte_budget_shaper_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef UPLOAD_BYTE_BUDGET_SHAPER_MACROS_SVH
`define UPLOAD_BYTE_BUDGET_SHAPER_MACROS_SVH

// Same-cycle implication on clk, quiet while arst_n is low
`define UBBS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication on clk, quiet while arst_n is low
`define UBBS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/ubbs_pkg.sv =====
package ubbs_pkg;

	typedef logic [1:0] req_t;

	localparam req_t REQ_TICK      = 2'd0;
	localparam req_t REQ_REPORT    = 2'd1;
	localparam req_t REQ_CLR_TOTAL = 2'd2;
	localparam req_t REQ_CLR_OVH   = 2'd3;

	localparam logic [10:0] FRAG_LOW       = 11'd536;
	localparam logic [10:0] FRAG_HIGH      = 11'd1300;
	localparam logic [11:0] CHUNK_HIGH     = 12'd2600;
	// rate multiple M = KiB/s, rate in bytes/s is M * 1024
	localparam logic [20:0] LOW_RATE_M     = 21'd6;
	localparam logic [20:0] UNLIMITED_M    = 21'h100000;
	localparam logic [17:0] CLAMP_EXTRA_MS = 18'd2000;
	localparam logic [9:0]  BACKOFF_CAP    = 10'd1000;
	localparam logic [16:0] SLEEP_MAX      = 17'd131071;
	localparam logic [6:0]  MAX_SLOTS      = 7'd64;

	// serial divider geometry
	localparam int NUM_W = 46;
	localparam int DEN_W = 28;
	localparam int CNT_W = 6;
	localparam logic [CNT_W-1:0] SLEEP_STEPS = 6'd38;
	localparam logic [CNT_W-1:0] TICK_STEPS  = 6'd46;
	// credit = M * el * 128 / 125
	localparam logic [DEN_W-1:0] TICK_DEN    = 28'd125;

	// sleep = backoff, or max(quotient + 2, backoff) while in deficit; saturate
	function automatic logic [16:0] sleep_pick(logic [NUM_W-1:0] quo, logic in_deficit,
			logic [9:0] backoff);
		logic [16:0] q2;
		if (quo >= NUM_W'(SLEEP_MAX - 17'd2)) begin
			q2 = SLEEP_MAX;
		end else begin
			q2 = quo[16:0] + 17'd2;
		end
		if (in_deficit && q2 > {7'b0, backoff}) begin
			return q2;
		end
		return {7'b0, backoff};
	endfunction

endpackage

// ===== hdl/upload_byte_budget_shaper.sv =====
// Byte-credit shaper for an upload link.
// Input channel in_valid/in_ready carries one request: tick (elapsed_ms), send
// report (spent_bytes, spent_overhead, slot_count) or read-and-clear of either
// byte counter. Each request yields exactly one result on out_valid/out_ready:
// next sleep time, credit, send permission, fragment sizes, refill wake flag
// and the cleared counter value. cfg_we/cfg_wdata write the KiB/s limit with no
// wait; write it only while no request is in flight.
// Flow: an accepted request first has the sleep time recomputed (S_PRE) if it is
// the first after reset or after a limit write, then is worked in S_EXEC; a tick
// then passes S_MUL and S_TDIV for the credit, and every request ends with
// S_SLOAD and S_POST for the sleep time and S_DONE. One bit-serial restoring
// divider produces one quotient bit per cycle: 38 steps for the sleep time and
// 46 for the tick credit. One request is in work at a time; a new one is taken
// once the previous result sits in the output register; a stalled receiver
// holds that register and the next finished result waits until it is free.
// Reset: credit 0, backoff 1 ms, counters 0, limit 0 (unlimited); the sleep time
// is recomputed before the first request is worked.
module upload_byte_budget_shaper (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [19:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic [19:0]        elapsed_ms,
	input  logic [30:0]        spent_bytes,
	input  logic [30:0]        spent_overhead,
	input  logic [6:0]         slot_count,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [16:0]        next_sleep_ms,
	output logic signed [31:0] budget_bytes,
	output logic               send_allowed,
	output logic [10:0]        min_fragment,
	output logic [11:0]        grant_chunk,
	output logic               wake_refill,
	output logic [63:0]        counter_value
);

	localparam int NW = ubbs_pkg::NUM_W;
	localparam int DW = ubbs_pkg::DEN_W;
	localparam int CW = ubbs_pkg::CNT_W;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PRE   = 3'd1;
	localparam logic [2:0] S_EXEC  = 3'd2;
	localparam logic [2:0] S_MUL   = 3'd3;
	localparam logic [2:0] S_TDIV  = 3'd4;
	localparam logic [2:0] S_SLOAD = 3'd5;
	localparam logic [2:0] S_POST  = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0]         state_q;
	logic               stale_q;
	logic [19:0]        kib_q;
	logic signed [31:0] budget_q;
	logic [9:0]         backoff_q;
	logic [16:0]        wanted_q;
	logic [63:0]        total_q;
	logic [63:0]        ovh_q;
	logic               out_valid_q;
	logic [CW-1:0]      cnt_q;

	ubbs_pkg::req_t     type_q;
	logic [19:0]        el_q;
	logic [30:0]        spent_q;
	logic [30:0]        over_q;
	logic [6:0]         slots_q;
	logic               wake_q;
	logic [63:0]        counter_q;
	logic [37:0]        prod_q;
	logic [DW-1:0]      rem_q;
	logic [NW-1:0]      num_q;
	logic [NW-1:0]      quo_q;
	logic [DW-1:0]      den_q;

	logic [16:0]        sleep_out_q;
	logic signed [31:0] budget_out_q;
	logic               allowed_out_q;
	logic [10:0]        frag_out_q;
	logic [11:0]        chunk_out_q;
	logic               wake_out_q;
	logic [63:0]        counter_out_q;

	logic [20:0]        m_rate;
	logic               low_rate;
	logic [10:0]        frag;
	logic [11:0]        chunk;
	logic               in_deficit;
	logic [32:0]        deficit;
	logic [39:0]        sleep_num;
	logic [17:0]        lim;
	logic [17:0]        el_c;
	logic [38:0]        prod_full;
	logic [DW:0]        trial;
	logic [DW:0]        diff;
	logic               ge;
	logic               div_step;
	logic               div_done;
	logic               load_sleep;
	logic               take;
	logic signed [47:0] tick_sum;
	logic signed [31:0] tick_budget;
	logic [6:0]         slots_c;
	logic [16:0]        lo_mag;
	logic signed [33:0] lo;
	logic signed [33:0] hi;
	logic signed [33:0] rep_nb;
	logic signed [31:0] rep_budget;
	logic [12:0]        backoff5;
	logic [9:0]         backoff_next;
	logic               rep_wake;

	assign m_rate     = (kib_q == 20'd0) ? ubbs_pkg::UNLIMITED_M : {1'b0, kib_q};
	assign low_rate   = m_rate < ubbs_pkg::LOW_RATE_M;
	assign frag       = low_rate ? ubbs_pkg::FRAG_LOW : ubbs_pkg::FRAG_HIGH;
	assign chunk      = low_rate ? {1'b0, ubbs_pkg::FRAG_LOW} : ubbs_pkg::CHUNK_HIGH;
	assign in_deficit = budget_q < 32'sd1;

	// deficit * 1000 / (M * 1024) == deficit * 125 / (M * 128)
	assign deficit   = 33'd1 - {budget_q[31], budget_q};
	assign sleep_num = {7'b0, deficit} * 40'd125;

	assign lim       = {1'b0, wanted_q} + ubbs_pkg::CLAMP_EXTRA_MS;
	assign el_c      = (el_q > {2'b0, lim}) ? lim : el_q[17:0];
	assign prod_full = {18'b0, m_rate} * {21'b0, el_c};

	assign trial    = {rem_q, num_q[NW-1]};
	assign ge       = trial >= {1'b0, den_q};
	assign diff     = trial - {1'b0, den_q};
	assign div_step = (state_q == S_PRE || state_q == S_TDIV || state_q == S_POST)
		&& cnt_q != '0;
	assign div_done = cnt_q == '0;

	assign take       = in_valid && state_q == S_IDLE;
	assign load_sleep = (take && stale_q) || state_q == S_SLOAD;

	assign tick_sum    = {{16{budget_q[31]}}, budget_q} + $signed({2'b0, quo_q});
	assign tick_budget = (tick_sum > 48'sd2147483647) ? 32'sh7FFFFFFF : tick_sum[31:0];

	assign slots_c  = (slots_q > ubbs_pkg::MAX_SLOTS) ? ubbs_pkg::MAX_SLOTS : slots_q;
	assign lo_mag   = ({10'b0, slots_c} + 17'd1) * {6'b0, frag};
	assign lo       = 34'sd0 - $signed({17'b0, lo_mag});
	assign hi       = $signed({18'b0, slots_c, 9'b0}) + 34'sd1;
	assign rep_nb   = {{2{budget_q[31]}}, budget_q} - $signed({3'b0, spent_q});
	assign rep_budget = (rep_nb < lo) ? lo[31:0] : ((rep_nb > hi) ? hi[31:0] : rep_nb[31:0]);
	assign backoff5 = {3'b0, backoff_q} * 13'd5;
	assign backoff_next = (spent_q != 31'd0) ? 10'd1 :
		((backoff5 > {3'b0, ubbs_pkg::BACKOFF_CAP}) ? ubbs_pkg::BACKOFF_CAP : backoff5[9:0]);
	assign rep_wake = spent_q != 31'd0 && spent_q > over_q;

	assign in_ready = state_q == S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			stale_q     <= 1'b1;
			kib_q       <= 20'd0;
			budget_q    <= 32'sd0;
			backoff_q   <= 10'd1;
			wanted_q    <= 17'd1;
			total_q     <= 64'd0;
			ovh_q       <= 64'd0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cfg_we) begin
				kib_q   <= cfg_wdata;
				stale_q <= 1'b1;
			end
			// hand over once the output register is free
			if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (div_step) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (load_sleep) begin
				cnt_q <= ubbs_pkg::SLEEP_STEPS;
			end
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						state_q <= stale_q ? S_PRE : S_EXEC;
					end
				end
				S_PRE: begin
					if (div_done) begin
						wanted_q <= ubbs_pkg::sleep_pick(quo_q, in_deficit, backoff_q);
						stale_q  <= 1'b0;
						state_q  <= S_EXEC;
					end
				end
				S_EXEC: begin
					unique case (type_q)
						ubbs_pkg::REQ_TICK: begin
							state_q <= S_MUL;
						end
						ubbs_pkg::REQ_REPORT: begin
							budget_q  <= rep_budget;
							total_q   <= total_q + {33'b0, spent_q};
							ovh_q     <= ovh_q + {33'b0, over_q};
							backoff_q <= backoff_next;
							state_q   <= S_SLOAD;
						end
						ubbs_pkg::REQ_CLR_TOTAL: begin
							total_q <= 64'd0;
							state_q <= S_SLOAD;
						end
						ubbs_pkg::REQ_CLR_OVH: begin
							ovh_q   <= 64'd0;
							state_q <= S_SLOAD;
						end
						default: state_q <= S_SLOAD;
					endcase
				end
				S_MUL: begin
					cnt_q   <= ubbs_pkg::TICK_STEPS;
					state_q <= S_TDIV;
				end
				S_TDIV: begin
					if (div_done) begin
						budget_q <= tick_budget;
						state_q  <= S_SLOAD;
					end
				end
				S_SLOAD: begin
					state_q <= S_POST;
				end
				S_POST: begin
					if (div_done) begin
						wanted_q <= ubbs_pkg::sleep_pick(quo_q, in_deficit, backoff_q);
						stale_q  <= 1'b0;
						state_q  <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			type_q  <= req_type;
			el_q    <= elapsed_ms;
			spent_q <= spent_bytes;
			over_q  <= spent_overhead;
			slots_q <= slot_count;
		end
		if (state_q == S_EXEC) begin
			prod_q    <= prod_full[37:0];
			wake_q    <= (type_q == ubbs_pkg::REQ_REPORT) ? rep_wake : 1'b0;
			counter_q <= (type_q == ubbs_pkg::REQ_CLR_TOTAL) ? total_q :
				((type_q == ubbs_pkg::REQ_CLR_OVH) ? ovh_q : 64'd0);
		end
		// one quotient bit per cycle, MSB first
		if (div_step) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			num_q <= {num_q[NW-2:0], 1'b0};
			quo_q <= {quo_q[NW-2:0], ge};
		end
		if (load_sleep) begin
			rem_q <= '0;
			quo_q <= '0;
			num_q <= {sleep_num[37:0], 8'b0};
			den_q <= {m_rate, 7'b0};
		end
		if (state_q == S_MUL) begin
			rem_q <= '0;
			quo_q <= '0;
			num_q <= {1'b0, prod_q, 7'b0};
			den_q <= ubbs_pkg::TICK_DEN;
		end
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			sleep_out_q   <= wanted_q;
			budget_out_q  <= budget_q;
			allowed_out_q <= !in_deficit;
			frag_out_q    <= frag;
			chunk_out_q   <= chunk;
			wake_out_q    <= wake_q;
			counter_out_q <= counter_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign next_sleep_ms = sleep_out_q;
	assign budget_bytes  = budget_out_q;
	assign send_allowed  = allowed_out_q;
	assign min_fragment  = frag_out_q;
	assign grant_chunk   = chunk_out_q;
	assign wake_refill   = wake_out_q;
	assign counter_value = counter_out_q;

endmodule

// ===== hdl/ubbs_checker.sv =====
`include "upload_byte_budget_shaper_macros.svh"

module ubbs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [16:0]        next_sleep_ms,
	input logic signed [31:0] budget_bytes,
	input logic [63:0]        counter_value
);

	// a stalled result holds
	`UBBS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(budget_bytes) && $stable(next_sleep_ms) && $stable(counter_value), "result changed while stalled")

	// one request in work at a time
	`UBBS_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "second transfer taken while busy")

	// a result only follows work on a request
	`UBBS_ASSERT_NOW(a_result_after_work, $rose(out_valid), $past(!in_ready), "result without a request in work")

endmodule

bind upload_byte_budget_shaper ubbs_checker u_ubbs_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam int STALL_LIMIT = 5000;
	localparam int ITEMS_PER_SETTING = 53;

	typedef struct packed {
		ubbs_pkg::req_t kind;
		logic [19:0]    elapsed;
		logic [30:0]    spent;
		logic [30:0]    overhead;
		logic [6:0]     slots;
	} shaper_req_t;

	typedef struct packed {
		logic [16:0]        sleep_ms;
		logic signed [31:0] budget;
		logic               allowed;
		logic [10:0]        frag;
		logic [11:0]        chunk;
		logic               wake;
		logic [63:0]        counter;
	} shaper_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [19:0]        cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         req_type = '0;
	logic [19:0]        elapsed_ms = '0;
	logic [30:0]        spent_bytes = '0;
	logic [30:0]        spent_overhead = '0;
	logic [6:0]         slot_count = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [16:0]        next_sleep_ms;
	logic signed [31:0] budget_bytes;
	logic               send_allowed;
	logic [10:0]        min_fragment;
	logic [11:0]        grant_chunk;
	logic               wake_refill;
	logic [63:0]        counter_value;

	upload_byte_budget_shaper u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.elapsed_ms    (elapsed_ms),
		.spent_bytes   (spent_bytes),
		.spent_overhead(spent_overhead),
		.slot_count    (slot_count),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.next_sleep_ms (next_sleep_ms),
		.budget_bytes  (budget_bytes),
		.send_allowed  (send_allowed),
		.min_fragment  (min_fragment),
		.grant_chunk   (grant_chunk),
		.wake_refill   (wake_refill),
		.counter_value (counter_value)
	);

	// shaper state mirrored by the testbench
	logic signed [31:0] credit = '0;
	logic [9:0]         backoff = 10'd1;
	logic [16:0]        sleep_ms = 17'd1;
	logic [63:0]        total_sent = '0;
	logic [63:0]        total_ovh = '0;
	logic [19:0]        limit_kib = '0;

	shaper_req_t    req_backlog[$];
	shaper_result_t due_results[$];
	shaper_req_t    on_wire;
	int             send_gap = 0;
	int             hold_off = 0;
	int             quiet_cycles = 0;
	int             errors = 0;
	int             results_seen = 0;
	int             settings_used = 1;
	int             kind_count[4] = '{0, 0, 0, 0};
	bit             calm = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic logic [63:0] rate_of(logic [19:0] kib);
		if (kib == '0)
			return 64'd1 << 30;
		return {44'd0, kib} * 64'd1024;
	endfunction

	function automatic logic [16:0] sleep_for(logic signed [31:0] c, logic [9:0] bo,
			logic [63:0] r);
		logic [63:0] s;
		logic [63:0] q;
		s = {54'd0, bo};
		if (c < 1) begin
			q = 64'(1 - longint'(c)) * 64'd1000 / r + 64'd2;
			if (q > s)
				s = q;
		end
		if (s > {47'd0, ubbs_pkg::SLEEP_MAX})
			s = {47'd0, ubbs_pkg::SLEEP_MAX};
		return s[16:0];
	endfunction

	// work out the result of one transfer and advance the mirrored state
	task automatic shape_step(input shaper_req_t rq);
		shaper_result_t res;
		logic [63:0] r;
		logic [63:0] el;
		logic [63:0] lim;
		logic [31:0] b;
		longint nb;
		longint lo;
		longint hi;
		longint slots;
		longint frag;
		bit low_rate;
		r = rate_of(limit_kib);
		low_rate = r < {43'd0, ubbs_pkg::LOW_RATE_M} * 64'd1024;
		res = '0;
		sleep_ms = sleep_for(credit, backoff, r);
		case (rq.kind)
			ubbs_pkg::REQ_TICK: begin
				el = {44'd0, rq.elapsed};
				lim = {47'd0, sleep_ms} + {46'd0, ubbs_pkg::CLAMP_EXTRA_MS};
				if (el > lim)
					el = lim;
				nb = longint'(credit) + longint'(r * el / 64'd1000);
				if (nb > 64'sd2147483647)
					nb = 64'sd2147483647;
				credit = nb[31:0];
			end
			ubbs_pkg::REQ_REPORT: begin
				slots = rq.slots > ubbs_pkg::MAX_SLOTS ? longint'(ubbs_pkg::MAX_SLOTS) :
					longint'(rq.slots);
				frag = low_rate ? longint'(ubbs_pkg::FRAG_LOW) : longint'(ubbs_pkg::FRAG_HIGH);
				lo = -((slots + 1) * frag);
				hi = slots * 512 + 1;
				nb = longint'(credit) - longint'({33'd0, rq.spent});
				if (nb < lo)
					nb = lo;
				else if (nb > hi)
					nb = hi;
				credit = nb[31:0];
				total_sent = total_sent + {33'd0, rq.spent};
				total_ovh = total_ovh + {33'd0, rq.overhead};
				if (rq.spent == '0) begin
					b = {22'd0, backoff} * 32'd5;
					backoff = b > {22'd0, ubbs_pkg::BACKOFF_CAP} ? ubbs_pkg::BACKOFF_CAP :
						b[9:0];
				end else begin
					backoff = 10'd1;
					res.wake = rq.spent > rq.overhead;
				end
			end
			ubbs_pkg::REQ_CLR_TOTAL: begin
				res.counter = total_sent;
				total_sent = '0;
			end
			ubbs_pkg::REQ_CLR_OVH: begin
				res.counter = total_ovh;
				total_ovh = '0;
			end
		endcase
		sleep_ms = sleep_for(credit, backoff, r);
		res.sleep_ms = sleep_ms;
		res.budget = credit;
		res.allowed = credit >= 1;
		res.frag = low_rate ? ubbs_pkg::FRAG_LOW : ubbs_pkg::FRAG_HIGH;
		res.chunk = low_rate ? {1'b0, ubbs_pkg::FRAG_LOW} : ubbs_pkg::CHUNK_HIGH;
		due_results = {due_results, res};
	endtask

	task automatic enqueue_req(input shaper_req_t rq);
		req_backlog = {req_backlog, rq};
	endtask

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic shaper_req_t mk_req(ubbs_pkg::req_t k, logic [19:0] el,
			logic [30:0] sp, logic [30:0] ov, logic [6:0] sl);
		shaper_req_t rq;
		rq.kind = k;
		rq.elapsed = el;
		rq.spent = sp;
		rq.overhead = ov;
		rq.slots = sl;
		return rq;
	endfunction

	function automatic shaper_req_t rand_req();
		shaper_req_t rq;
		int k;
		rq.kind = ubbs_pkg::req_t'($urandom_range(0, 3));
		rq.elapsed = 20'($urandom);
		rq.spent = 31'($urandom);
		rq.overhead = 31'($urandom);
		rq.slots = 7'($urandom);
		// mostly plausible loop traffic, the rest left as full-width noise
		if ($urandom_range(0, 99) < 85) begin
			k = $urandom_range(0, 9);
			rq.kind = k < 4 ? ubbs_pkg::REQ_TICK : k < 8 ? ubbs_pkg::REQ_REPORT :
				k == 8 ? ubbs_pkg::REQ_CLR_TOTAL : ubbs_pkg::REQ_CLR_OVH;
			k = $urandom_range(0, 9);
			if (k < 6)
				rq.elapsed = 20'($urandom_range(0, 20));
			else if (k < 9)
				rq.elapsed = 20'($urandom_range(0, 4000));
			k = $urandom_range(0, 9);
			if (k < 2)
				rq.spent = '0;
			else if (k < 7)
				rq.spent = 31'($urandom_range(1, 3000));
			else if (k < 9)
				rq.spent = 31'($urandom_range(3000, 200000));
			k = $urandom_range(0, 9);
			if (k < 3)
				rq.overhead = '0;
			else if (k < 8)
				rq.overhead = 31'($urandom_range(0, rq.spent));
			if ($urandom_range(0, 9) < 8)
				rq.slots = 7'($urandom_range(0, 64));
			else
				rq.slots = 7'($urandom_range(65, 127));
		end
		return rq;
	endfunction

	task automatic check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			errors++;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				shape_step(on_wire);
				kind_count[on_wire.kind]++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (req_backlog.size() > 0) begin
					on_wire = req_backlog[0];
					req_backlog.delete(0);
					req_type <= on_wire.kind;
					elapsed_ms <= on_wire.elapsed;
					spent_bytes <= on_wire.spent;
					spent_overhead <= on_wire.overhead;
					slot_count <= on_wire.slots;
					in_valid <= 1'b1;
					send_gap = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		shaper_result_t exp_r;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_off = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					$error("result transfer with no request outstanding");
					errors++;
				end else begin
					exp_r = due_results[0];
					due_results.delete(0);
					results_seen++;
					check_field("next_sleep_ms", 64'(exp_r.sleep_ms), 64'(next_sleep_ms));
					check_field("budget_bytes", 64'(exp_r.budget), 64'(budget_bytes));
					check_field("send_allowed", 64'(exp_r.allowed), 64'(send_allowed));
					check_field("min_fragment", 64'(exp_r.frag), 64'(min_fragment));
					check_field("grant_chunk", 64'(exp_r.chunk), 64'(grant_chunk));
					check_field("wake_refill", 64'(exp_r.wake), 64'(wake_refill));
					check_field("counter_value", exp_r.counter, counter_value);
				end
			end
			if (hold_off > 0) begin
				hold_off--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					hold_off = pick_gap();
			end
		end
	end

	// watchdog: abort when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles < STALL_LIMIT) begin
			quiet_cycles <= quiet_cycles + 1;
		end else begin
			$display("upload_byte_budget_shaper verification failed");
			$finish;
		end
	end

	task automatic wait_drained();
		do
			@(negedge clk);
		while (req_backlog.size() != 0 || in_valid || due_results.size() != 0);
		repeat (10) @(negedge clk);
	endtask

	initial begin
		logic [19:0] kib_plan[9];
		kib_plan = '{20'd1, 20'd5, 20'd6, 20'hFFFFF, 20'd0, 20'($urandom_range(7, 1000)),
			20'($urandom_range(1, 20'hFFFFF)), 20'd100, 20'd2};
		wait (arst_n === 1'b1);
		@(negedge clk);

		// directed: counters empty, credit saturation, deficit clamp, backoff to cap
		enqueue_req(mk_req(ubbs_pkg::REQ_CLR_TOTAL, '0, '0, '0, '0));
		enqueue_req(mk_req(ubbs_pkg::REQ_CLR_OVH, '0, '0, '0, '0));
		enqueue_req(mk_req(ubbs_pkg::REQ_TICK, '0, '0, '0, '0));
		enqueue_req(mk_req(ubbs_pkg::REQ_TICK, 20'hFFFFF, '0, '0, '0));
		enqueue_req(mk_req(ubbs_pkg::REQ_REPORT, '0, 31'h7FFFFFFF, '0, 7'h7F));
		enqueue_req(mk_req(ubbs_pkg::REQ_TICK, 20'd1, '0, '0, '0));
		enqueue_req(mk_req(ubbs_pkg::REQ_REPORT, '0, 31'd100, 31'd200, '0));
		enqueue_req(mk_req(ubbs_pkg::REQ_REPORT, '0, '0, 31'h7FFFFFFF, 7'd64));
		repeat (4)
			enqueue_req(mk_req(ubbs_pkg::REQ_REPORT, '0, '0, '0, 7'd64));
		enqueue_req(mk_req(ubbs_pkg::REQ_TICK, 20'd5000, '0, '0, '0));
		enqueue_req(mk_req(ubbs_pkg::REQ_REPORT, '0, 31'd1, '0, '0));
		enqueue_req(mk_req(ubbs_pkg::REQ_TICK, 20'd3, '0, '0, '0));
		enqueue_req(mk_req(ubbs_pkg::REQ_REPORT, '0, 31'd1, '0, 7'd64));
		enqueue_req(mk_req(ubbs_pkg::REQ_CLR_TOTAL, '0, '0, '0, '0));
		enqueue_req(mk_req(ubbs_pkg::REQ_CLR_OVH, '0, '0, '0, '0));
		enqueue_req(mk_req(ubbs_pkg::REQ_CLR_TOTAL, '0, '0, '0, '0));
		enqueue_req(mk_req(ubbs_pkg::REQ_REPORT, 20'hFFFFF, 31'd2, 31'd1, 7'd1));
		enqueue_req(mk_req(ubbs_pkg::REQ_TICK, 20'd1000, 31'h7FFFFFFF, 31'h7FFFFFFF,
			7'h7F));
		enqueue_req(mk_req(ubbs_pkg::REQ_CLR_OVH, 20'hFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF,
			7'h7F));

		foreach (kib_plan[i]) begin
			wait_drained();
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_wdata <= kib_plan[i];
			limit_kib = kib_plan[i];
			@(posedge clk);
			cfg_we <= 1'b0;
			@(negedge clk);
			settings_used++;
			calm = (i % 3 == 2);
			repeat (ITEMS_PER_SETTING)
				enqueue_req(rand_req());
		end

		wait_drained();
		repeat (150) @(negedge clk);
		$display("Run covered %0d ticks, %0d send reports and %0d counter read-clears",
			kind_count[ubbs_pkg::REQ_TICK], kind_count[ubbs_pkg::REQ_REPORT],
			kind_count[ubbs_pkg::REQ_CLR_TOTAL] + kind_count[ubbs_pkg::REQ_CLR_OVH]);
		$display("over %0d rate limits, with %0d results compared field by field",
			settings_used, results_seen);
		if (due_results.size() != 0) begin
			$error("%0d results never arrived", due_results.size());
			errors++;
		end
		if (errors == 0)
			$display("upload_byte_budget_shaper verification clean");
		else
			$display("upload_byte_budget_shaper verification failed");
		$finish;
	end

endmodule
